// ===== hw/rtl/voice_limit_load_governor_defines.svh =====
// assertion macros for the voice limit load governor
`ifndef VOICE_LIMIT_LOAD_GOVERNOR_DEFINES_SVH
`define VOICE_LIMIT_LOAD_GOVERNOR_DEFINES_SVH

// checked only while out of reset
`define VLG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define VLG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/vlg_pkg.sv =====
// types and constants shared by the voice limit load governor
`timescale 1ns / 1ps

package vlg_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EMERG = 2'd1,
    OP_APPLY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_VOICE_MODE  = 2'd0,
    REG_SAMPLE_RATE = 2'd1,
    REG_AUTO_FLOOR  = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_idx_e;

  localparam logic [2:0]  MODE_AUTO     = 3'd4;
  localparam logic [7:0]  CUT_LOAD      = 8'd90;
  localparam logic [7:0]  COOL_LOAD     = 8'd70;
  localparam logic [5:0]  CUT_STEP      = 6'd6;
  localparam logic [15:0] RATE_LOW_BASE = 16'd32000;
  localparam logic [5:0]  BASE_LOW      = 6'd12;
  localparam logic [5:0]  BASE_HIGH     = 6'd16;
  localparam logic [5:0]  LIMIT_MAX     = 6'd32;

  localparam logic [5:0] MANUAL_LIMITS [4] = '{6'd8, 6'd16, 6'd24, 6'd32};

  localparam logic [2:0]  MODE_RESET  = MODE_AUTO;
  localparam logic [15:0] RATE_RESET  = 16'd20000;
  localparam logic [3:0]  FLOOR_RESET = 4'd4;

  // hold length = rate * 7 / 10, done as one multiply by a scaled reciprocal
  localparam int unsigned HOLD_NUM   = 7;
  localparam int unsigned HOLD_DEN   = 10;
  localparam int unsigned HOLD_SHIFT = 23;
  localparam int unsigned HOLD_RECIP = ((1 << HOLD_SHIFT) + HOLD_DEN - 1) / HOLD_DEN;
  localparam logic [22:0] HOLD_MULT  = 23'(HOLD_NUM * HOLD_RECIP);
  localparam logic [15:0] HOLD_RESET = 16'((20000 * HOLD_NUM) / HOLD_DEN);

  typedef struct packed {
    op_e         op;
    logic [7:0]  load_percent;
    logic [11:0] sample_count;
  } item_t;

  typedef struct packed {
    logic [5:0] voice_limit;
    logic       limit_pushed;
  } result_t;

  typedef struct packed {
    logic [2:0]  voice_mode;
    logic [15:0] sample_rate;
    logic [3:0]  auto_floor;
    logic [15:0] hold_len;
  } gov_cfg_t;

  typedef struct packed {
    logic [5:0]  auto_limit;
    logic [15:0] hold_count;
    logic [5:0]  effective_limit;
  } gov_state_t;

endpackage

// ===== hw/rtl/vlg_item_if.sv =====
// input item channel
`timescale 1ns / 1ps

interface vlg_item_if;
  logic           valid;
  logic           ready;
  vlg_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vlg_result_if.sv =====
// result item channel
`timescale 1ns / 1ps

interface vlg_result_if;
  logic             valid;
  logic             ready;
  vlg_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/vlg_cfg_if.sv =====
// configuration write channel
`timescale 1ns / 1ps

interface vlg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vlg_step.sv =====
// next state and result of the governor for one item
`timescale 1ns / 1ps

module vlg_step (
  input  vlg_pkg::gov_cfg_t   cfg_i,
  input  vlg_pkg::gov_state_t state_i,
  input  vlg_pkg::item_t      item_i,
  output vlg_pkg::gov_state_t state_o,
  output vlg_pkg::result_t    result_o
);
  import vlg_pkg::*;

  logic        is_auto;
  logic [5:0]  base;
  logic [5:0]  floor6;
  logic [5:0]  cut_val;
  logic [5:0]  cut_clamped;
  logic [5:0]  emerg_clamped;
  logic [5:0]  rise;
  logic [5:0]  rise_floored;
  logic [5:0]  rise_clamped;
  logic [15:0] hold_start;
  logic [15:0] count16;
  logic [5:0]  lim;
  logic        pushed;
  gov_state_t  nxt;

  always_comb begin
    is_auto       = cfg_i.voice_mode >= MODE_AUTO;
    base          = (cfg_i.sample_rate == RATE_LOW_BASE) ? BASE_LOW : BASE_HIGH;
    floor6        = {2'b00, cfg_i.auto_floor};
    cut_val       = (state_i.auto_limit >= floor6 + CUT_STEP) ?
                    state_i.auto_limit - CUT_STEP : floor6;
    cut_clamped   = (cut_val > base) ? base : cut_val;
    emerg_clamped = (floor6 > base) ? base : floor6;
    rise          = state_i.auto_limit + 6'd1;
    rise_floored  = (rise < floor6) ? floor6 : rise;
    rise_clamped  = (rise_floored > base) ? base : rise_floored;
    hold_start    = (state_i.hold_count == 16'd0) ? cfg_i.hold_len : state_i.hold_count;
    count16       = {4'd0, item_i.sample_count};
    lim           = MANUAL_LIMITS[cfg_i.voice_mode[1:0]];
    nxt           = state_i;
    pushed        = 1'b0;

    unique case (item_i.op)
      OP_TICK: begin
        if (is_auto) begin
          if (item_i.load_percent >= CUT_LOAD) begin
            if (state_i.auto_limit > floor6) begin
              nxt.auto_limit = cut_clamped;
            end
            nxt.hold_count      = 16'd0;
            nxt.effective_limit = nxt.auto_limit;
            pushed              = 1'b1;
          end else if (item_i.load_percent < COOL_LOAD && state_i.auto_limit < base) begin
            if (count16 >= hold_start) begin
              nxt.auto_limit      = rise_clamped;
              nxt.effective_limit = rise_clamped;
              nxt.hold_count      = 16'd0;
              pushed              = rise_clamped != state_i.effective_limit;
            end else begin
              nxt.hold_count = hold_start - count16;
            end
          end
        end
      end
      OP_EMERG: begin
        if (is_auto) begin
          if (state_i.auto_limit > floor6) begin
            nxt.auto_limit = emerg_clamped;
          end
          nxt.hold_count      = 16'd0;
          nxt.effective_limit = nxt.auto_limit;
          pushed              = 1'b1;
        end
      end
      OP_APPLY: begin
        if (is_auto) begin
          nxt.auto_limit = base;
          nxt.hold_count = 16'd0;
          lim            = base;
        end
        nxt.effective_limit = lim;
        pushed              = lim != state_i.effective_limit;
      end
      OP_NONE: begin
        nxt = state_i;
      end
      default: begin
        nxt = state_i;
      end
    endcase

    state_o                = nxt;
    result_o.voice_limit   = nxt.effective_limit;
    result_o.limit_pushed  = pushed;
  end

endmodule

// ===== hw/rtl/voice_limit_load_governor.sv =====
// Voice limit load governor: takes one transaction per clock cycle, back to back, and
// delivers its result through the input register and then the result register; the
// input stalls only while the input register holds a transaction and the result
// register ahead of it is full and not being taken. Throughput is set by the
// combinational update of the governor state between those two registers.
// Configuration writes are always ready and take effect on the next transaction; the
// recovery hold length is derived from the sample rate by one multiply at write time.
`timescale 1ns / 1ps
`include "voice_limit_load_governor_defines.svh"

module voice_limit_load_governor (
  input  logic         clk_i,
  input  logic         rst_ni,
  vlg_item_if.sink     item_i,
  vlg_result_if.source result_o,
  vlg_cfg_if.sink      cfg_i
);
  import vlg_pkg::*;

  logic [2:0]  voice_mode_q, voice_mode_d;
  logic [15:0] sample_rate_q, sample_rate_d;
  logic [3:0]  auto_floor_q, auto_floor_d;
  logic [15:0] hold_len_q, hold_len_d;
  logic [38:0] hold_prod;

  logic       s1_valid_q, s1_valid_d;
  item_t      s1_item_q, s1_item_d;
  logic       res_valid_q, res_valid_d;
  result_t    res_q, res_d;
  gov_state_t state_q, state_d;

  gov_cfg_t   cfg;
  gov_state_t step_state;
  result_t    step_result;
  logic       advance;
  logic       in_ready;

  // configuration
  assign cfg_i.ready = 1'b1;
  assign hold_prod   = 39'(cfg_i.data) * 39'(HOLD_MULT);

  always_comb begin
    voice_mode_d  = voice_mode_q;
    sample_rate_d = sample_rate_q;
    auto_floor_d  = auto_floor_q;
    hold_len_d    = hold_len_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        REG_VOICE_MODE:  voice_mode_d = cfg_i.data[2:0];
        REG_SAMPLE_RATE: begin
          sample_rate_d = cfg_i.data;
          hold_len_d    = hold_prod[HOLD_SHIFT +: 16];
        end
        REG_AUTO_FLOOR:  auto_floor_d = cfg_i.data[3:0];
        default: begin
          voice_mode_d = voice_mode_q;
        end
      endcase
    end
  end

  assign cfg = '{voice_mode: voice_mode_q, sample_rate: sample_rate_q,
                 auto_floor: auto_floor_q, hold_len: hold_len_q};

  // pipeline control
  assign advance      = s1_valid_q && (!res_valid_q || result_o.ready);
  assign in_ready     = !s1_valid_q || advance;
  assign item_i.ready = in_ready;

  vlg_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .item_i  (s1_item_q),
    .state_o (step_state),
    .result_o(step_result)
  );

  always_comb begin
    s1_valid_d  = s1_valid_q;
    s1_item_d   = s1_item_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    state_d     = state_q;
    if (in_ready) begin
      s1_valid_d = item_i.valid;
      s1_item_d  = item_i.data;
    end
    if (advance) begin
      res_valid_d = 1'b1;
      res_d       = step_result;
      state_d     = step_state;
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_mode_q  <= MODE_RESET;
      sample_rate_q <= RATE_RESET;
      auto_floor_q  <= FLOOR_RESET;
      hold_len_q    <= HOLD_RESET;
      s1_valid_q    <= 1'b0;
      res_valid_q   <= 1'b0;
      state_q       <= '{auto_limit: BASE_HIGH, hold_count: 16'd0,
                         effective_limit: BASE_HIGH};
    end else begin
      voice_mode_q  <= voice_mode_d;
      sample_rate_q <= sample_rate_d;
      auto_floor_q  <= auto_floor_d;
      hold_len_q    <= hold_len_d;
      s1_valid_q    <= s1_valid_d;
      res_valid_q   <= res_valid_d;
      state_q       <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_item_q <= s1_item_d;
    res_q     <= res_d;
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

  // checks
  `VLG_ASSERT(a_in_stall_cause,
    !item_i.ready |-> (s1_valid_q && res_valid_q && !result_o.ready),
    "input stalled without a blocked result")
  `VLG_ASSERT(a_res_from_stage,
    $rose(res_valid_q) |-> $past(s1_valid_q),
    "result appeared without a staged transaction")
  `VLG_ASSERT(a_auto_bound,
    state_q.auto_limit <= BASE_HIGH,
    "auto limit above base")
  `VLG_ASSERT(a_eff_bound,
    state_q.effective_limit <= LIMIT_MAX,
    "voice limit above maximum")

endmodule
